>>> hdl/ddet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddet_pkg
// Shared types and constants of the deadlock detector: command and result
// item layouts, operation codes and work counter limits.
// ----------------------------------------------------------------------------
package ddet_pkg;

    // operation codes
    localparam logic [2:0] OP_LOAD_EXIST  = 3'd0;
    localparam logic [2:0] OP_LOAD_SECOND = 3'd1;
    localparam logic [2:0] OP_LOAD_ALLOC  = 3'd2;
    localparam logic [2:0] OP_LOAD_REQ    = 3'd3;
    localparam logic [2:0] OP_RUN         = 3'd4;

    // work counter width and saturation value
    localparam int unsigned WORK_W = 11;
    localparam logic [WORK_W-1:0] WORK_MAX = '1;

    // reachable table extent set by the index field widths
    localparam int unsigned MAX_ROWS = 8;
    localparam int unsigned MAX_COLS = 4;

    // command item
    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] process_index;
        logic [1:0] resource_index;
        logic [7:0] value;
    } t_cmd;

    // result item
    typedef struct packed {
        logic [7:0] deadlocked_mask;
        logic       no_deadlock;
    } t_result;

endpackage
`default_nettype wire

>>> hdl/deadlock_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadlock_detector
// Multi-resource deadlock detection over an allocation and a request table,
// using one shared add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A command item on i_cmd is taken at a rising edge where start is high and
//   busy is low. Load items (existing, second vector, allocation, request)
//   write one table entry in that same edge; busy stays low.
//   A run item raises busy and starts the sequencer. It first builds the work
//   vector (existing minus second, clamped at zero), one resource per cycle,
//   then sweeps the processes: it skips a finished process, makes one compare
//   per resource of the request row, and on a fit one saturating add per
//   resource of the allocation row. Sweeps repeat until one makes no
//   progress.
//   The result shows on o_result for exactly one cycle with o_done high, in
//   the cycle where busy falls; the receiver cannot stall it.
//   Reset clears every table, the work vector and the finished flags.
// ----------------------------------------------------------------------------
module deadlock_detector #(
    parameter int unsigned NUM_PROCS = 8,
    parameter int unsigned NUM_RES   = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire ddet_pkg::t_cmd   i_cmd,
    output logic                  busy,
    output logic                  o_done,
    output ddet_pkg::t_result     o_result
);

    // only rows and columns reachable through the index fields hold data
    localparam int unsigned LP = (NUM_PROCS < ddet_pkg::MAX_ROWS) ? NUM_PROCS
                                                                  : ddet_pkg::MAX_ROWS;
    localparam int unsigned LR = (NUM_RES < ddet_pkg::MAX_COLS) ? NUM_RES
                                                                : ddet_pkg::MAX_COLS;
    localparam int unsigned PW = (LP > 1) ? $clog2(LP) : 1;
    localparam int unsigned RW = (LR > 1) ? $clog2(LR) : 1;
    localparam int unsigned WW = ddet_pkg::WORK_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_CHECK,
        S_ADD
    } t_state;

    // tables
    logic [7:0]    r_exist  [LR];
    logic [7:0]    r_second [LR];
    logic [7:0]    r_alloc  [LP][LR];
    logic [7:0]    r_req    [LP][LR];

    // sequencer state
    t_state        r_state, n_state;
    logic [PW-1:0] r_p, n_p;
    logic [RW-1:0] r_r, n_r;
    logic          r_progress, n_progress;
    logic          r_done, n_done;
    ddet_pkg::t_result r_result, n_result;
    logic [WW-1:0] r_work [LR];
    logic [LP-1:0] r_finished;

    logic          accept;
    logic          idx_p_ok, idx_r_ok;
    logic [PW-1:0] wr_p;
    logic [RW-1:0] wr_r;
    logic          res_last, proc_last;
    logic          work_we, fin_clr, fin_set, adv, prog_now;
    logic [WW-1:0] n_work_val;
    logic [LP-1:0] unfinished;

    // shared add/subtract unit
    logic [WW-1:0] u_a, u_b;
    logic          u_sub;
    logic [WW:0]   u_sum;

    assign accept     = start && !busy;
    assign busy       = (r_state != S_IDLE);
    assign idx_p_ok   = (32'(i_cmd.process_index) < LP);
    assign idx_r_ok   = (32'(i_cmd.resource_index) < LR);
    assign wr_p       = PW'(i_cmd.process_index);
    assign wr_r       = RW'(i_cmd.resource_index);
    assign res_last   = (r_r == RW'(LR - 1));
    assign proc_last  = (r_p == PW'(LP - 1));
    assign unfinished = ~r_finished;

    // table writes from load items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < LR; r++) begin
                r_exist[r]  <= '0;
                r_second[r] <= '0;
            end
            for (int p = 0; p < LP; p++) begin
                for (int r = 0; r < LR; r++) begin
                    r_alloc[p][r] <= '0;
                    r_req[p][r]   <= '0;
                end
            end
        end else if (accept) begin
            case (i_cmd.operation)
                ddet_pkg::OP_LOAD_EXIST: begin
                    if (idx_r_ok) r_exist[wr_r] <= i_cmd.value;
                end
                ddet_pkg::OP_LOAD_SECOND: begin
                    if (idx_r_ok) r_second[wr_r] <= i_cmd.value;
                end
                ddet_pkg::OP_LOAD_ALLOC: begin
                    if (idx_p_ok && idx_r_ok) r_alloc[wr_p][wr_r] <= i_cmd.value;
                end
                ddet_pkg::OP_LOAD_REQ: begin
                    if (idx_p_ok && idx_r_ok) r_req[wr_p][wr_r] <= i_cmd.value;
                end
                default: begin
                end
            endcase
        end
    end

    // operand selection for the shared unit
    always_comb begin
        u_a   = r_work[r_r];
        u_b   = WW'(r_req[r_p][r_r]);
        u_sub = 1'b1;
        case (r_state)
            S_INIT: begin
                u_a = WW'(r_exist[r_r]);
                u_b = WW'(r_second[r_r]);
            end
            S_ADD: begin
                u_b   = WW'(r_alloc[r_p][r_r]);
                u_sub = 1'b0;
            end
            default: begin
            end
        endcase
        // on subtract the top bit is set when u_a >= u_b
        u_sum = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + (WW + 1)'(u_sub);
    end

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_p        = r_p;
        n_r        = r_r;
        n_progress = r_progress;
        n_done     = 1'b0;
        n_result   = r_result;
        work_we    = 1'b0;
        n_work_val = u_sum[WW-1:0];
        fin_clr    = 1'b0;
        fin_set    = 1'b0;
        adv        = 1'b0;
        prog_now   = r_progress;

        case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd.operation == ddet_pkg::OP_RUN)) begin
                    n_state = S_INIT;
                    n_r     = '0;
                    fin_clr = 1'b1;
                end
            end
            // work = existing - second, clamped at zero
            S_INIT: begin
                work_we    = 1'b1;
                n_work_val = u_sum[WW] ? u_sum[WW-1:0] : '0;
                if (res_last) begin
                    n_state    = S_CHECK;
                    n_r        = '0;
                    n_p        = '0;
                    n_progress = 1'b0;
                end else begin
                    n_r = r_r + RW'(1);
                end
            end
            // request row against work, one resource a cycle
            S_CHECK: begin
                if (r_finished[r_p] || !u_sum[WW]) begin
                    adv = 1'b1;
                end else if (res_last) begin
                    n_state = S_ADD;
                    n_r     = '0;
                end else begin
                    n_r = r_r + RW'(1);
                end
            end
            // release the allocation row into work, saturating
            S_ADD: begin
                work_we    = 1'b1;
                n_work_val = u_sum[WW] ? ddet_pkg::WORK_MAX : u_sum[WW-1:0];
                if (res_last) begin
                    fin_set  = 1'b1;
                    prog_now = 1'b1;
                    adv      = 1'b1;
                end else begin
                    n_r = r_r + RW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // move on to the next process, new sweep or finish
        if (adv) begin
            n_r = '0;
            if (proc_last) begin
                if (prog_now) begin
                    n_p        = '0;
                    n_progress = 1'b0;
                    n_state    = S_CHECK;
                end else begin
                    n_state                  = S_IDLE;
                    n_done                   = 1'b1;
                    n_result.deadlocked_mask = 8'(unfinished);
                    n_result.no_deadlock     = &r_finished;
                end
            end else begin
                n_p        = r_p + PW'(1);
                n_progress = prog_now;
                n_state    = S_CHECK;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_p        <= '0;
            r_r        <= '0;
            r_progress <= 1'b0;
            r_done     <= 1'b0;
            r_result   <= '0;
            r_finished <= '0;
            for (int r = 0; r < LR; r++) begin
                r_work[r] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_p        <= n_p;
            r_r        <= n_r;
            r_progress <= n_progress;
            r_done     <= n_done;
            r_result   <= n_result;
            if (work_we) begin
                r_work[r_r] <= n_work_val;
            end
            if (fin_clr) begin
                r_finished <= '0;
            end else if (fin_set) begin
                r_finished[r_p] <= 1'b1;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
`default_nettype wire

>>> hdl/ddet_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddet_chk
// Port-level checks of the deadlock detector: run start, result strobe and
// result consistency.
// ----------------------------------------------------------------------------
module ddet_chk (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire ddet_pkg::t_cmd    i_cmd,
    input wire logic              busy,
    input wire logic              o_done,
    input wire ddet_pkg::t_result o_result
);

    // a run item makes the block busy
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.operation == ddet_pkg::OP_RUN)) |=> busy)
        else $error("run item did not raise busy");

    // the result strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // a run ends only with a result
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("busy fell without a result");

    // the flag agrees with the mask
    a_flag_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.no_deadlock == (o_result.deadlocked_mask == 8'd0)))
        else $error("no_deadlock disagrees with deadlocked_mask");

endmodule

bind deadlock_detector ddet_chk u_ddet_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_cmd    (i_cmd),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
`default_nettype wire

>>> verif/ddet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddet_checker
// Watches the command and result channels of the deadlock detector, keeps a
// shadow copy of its tables, predicts the verdict of every run item and
// compares each strobed result with the oldest outstanding verdict.
// ----------------------------------------------------------------------------
module ddet_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire ddet_pkg::t_cmd    i_cmd,
    input  wire logic              i_done,
    input  wire ddet_pkg::t_result i_result,
    output int                     o_errors,
    output int                     o_pending
);

    localparam int unsigned NPROC = 8;
    localparam int unsigned NRES  = 4;

    // shadow tables
    logic [7:0] exist_tbl  [NRES];
    logic [7:0] second_tbl [NRES];
    logic [7:0] alloc_tbl  [NPROC][NRES];
    logic [7:0] req_tbl    [NPROC][NRES];

    // verdicts of accepted run items not yet seen on the result port
    ddet_pkg::t_result pending_verdicts [$];

    // work through the safety sweep and report the processes left over
    function automatic ddet_pkg::t_result detect_deadlock();
        logic [ddet_pkg::WORK_W-1:0] work [NRES];
        logic [NPROC-1:0]            fin_flags;
        logic [ddet_pkg::WORK_W:0]   sum;
        logic                        progress;
        logic                        fits;
        ddet_pkg::t_result           verdict;
        for (int r = 0; r < NRES; r++) begin
            if (exist_tbl[r] > second_tbl[r]) begin
                work[r] = {3'b000, exist_tbl[r] - second_tbl[r]};
            end else begin
                work[r] = '0;
            end
        end
        fin_flags = '0;
        progress  = 1'b1;
        while (progress) begin
            progress = 1'b0;
            // lowest-numbered unfinished process whose request fits
            for (int p = 0; p < NPROC && !progress; p++) begin
                if (!fin_flags[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < NRES; r++) begin
                        if ({3'b000, req_tbl[p][r]} > work[r]) begin
                            fits = 1'b0;
                        end
                    end
                    if (fits) begin
                        // release its allocation, saturating the work count
                        for (int r = 0; r < NRES; r++) begin
                            sum = {1'b0, work[r]} + {4'b0000, alloc_tbl[p][r]};
                            if (sum > {1'b0, ddet_pkg::WORK_MAX}) begin
                                work[r] = ddet_pkg::WORK_MAX;
                            end else begin
                                work[r] = sum[ddet_pkg::WORK_W-1:0];
                            end
                        end
                        fin_flags[p] = 1'b1;
                        progress     = 1'b1;
                    end
                end
            end
        end
        verdict.deadlocked_mask = ~fin_flags;
        verdict.no_deadlock     = &fin_flags;
        return verdict;
    endfunction

    always @(posedge i_clk) begin
        ddet_pkg::t_result want;
        if (!i_rst_n) begin
            for (int r = 0; r < NRES; r++) begin
                exist_tbl[r]  = '0;
                second_tbl[r] = '0;
                for (int p = 0; p < NPROC; p++) begin
                    alloc_tbl[p][r] = '0;
                    req_tbl[p][r]   = '0;
                end
            end
            pending_verdicts.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            // result side: compare with the oldest verdict
            if (i_done === 1'b1) begin
                if (pending_verdicts.size() == 0) begin
                    $error("result with no run outstanding: mask %h no_deadlock %b",
                           i_result.deadlocked_mask, i_result.no_deadlock);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (i_result.deadlocked_mask !== want.deadlocked_mask) begin
                        $error("deadlocked_mask mismatch: expected %h, actual %h",
                               want.deadlocked_mask, i_result.deadlocked_mask);
                        o_errors <= o_errors + 1;
                    end else if (i_result.no_deadlock !== want.no_deadlock) begin
                        $error("no_deadlock mismatch: expected %b, actual %b",
                               want.no_deadlock, i_result.no_deadlock);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            // command side: update tables or predict a run
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                case (i_cmd.operation)
                    ddet_pkg::OP_LOAD_EXIST: begin
                        exist_tbl[i_cmd.resource_index] = i_cmd.value;
                    end
                    ddet_pkg::OP_LOAD_SECOND: begin
                        second_tbl[i_cmd.resource_index] = i_cmd.value;
                    end
                    ddet_pkg::OP_LOAD_ALLOC: begin
                        alloc_tbl[i_cmd.process_index][i_cmd.resource_index] = i_cmd.value;
                    end
                    ddet_pkg::OP_LOAD_REQ: begin
                        req_tbl[i_cmd.process_index][i_cmd.resource_index] = i_cmd.value;
                    end
                    ddet_pkg::OP_RUN: begin
                        pending_verdicts.push_back(detect_deadlock());
                    end
                    default: begin
                    end
                endcase
            end
            o_pending <= pending_verdicts.size();
        end
    end

endmodule

>>> verif/deadlock_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadlock_detector_tb
// Drives load and run items into the deadlock detector: a directed opening
// on table extremes, clamping, saturation and unknown codes, then random
// table scenarios, most closed by a run, with random start gaps. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module deadlock_detector_tb;

    localparam int CLK_PERIOD  = 4;
    localparam int NUM_ITEMS   = 1500;
    localparam int QUIET_ITEMS = 200;
    localparam int TAIL_CYCLES = 600;
    localparam int CYCLE_LIMIT = 5000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    ddet_pkg::t_cmd    i_cmd;
    logic              busy;
    logic              o_done;
    ddet_pkg::t_result o_result;
    int                error_count;
    int                runs_outstanding;
    int                cycle_count;
    int                items_sent;
    logic              gaps_on;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    deadlock_detector uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    ddet_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_cmd     (i_cmd),
        .i_done    (o_done),
        .i_result  (o_result),
        .o_errors  (error_count),
        .o_pending (runs_outstanding)
    );

    function automatic ddet_pkg::t_cmd make_cmd(logic [2:0] op, logic [2:0] p,
                                                logic [1:0] r, logic [7:0] v);
        ddet_pkg::t_cmd c;
        c.operation      = op;
        c.process_index  = p;
        c.resource_index = r;
        c.value          = v;
        return c;
    endfunction

    // resource count biased toward small numbers and extremes
    function automatic logic [7:0] pick_count();
        logic [7:0] v;
        case ($urandom_range(0, 3))
            0: v = 8'($urandom_range(0, 3));
            1: begin
                case ($urandom_range(0, 3))
                    0: v = 8'd0;
                    1: v = 8'd1;
                    2: v = 8'd254;
                    default: v = 8'd255;
                endcase
            end
            2: v = 8'($urandom_range(0, 15));
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // present one item, with an optional start gap, and wait for acceptance
    task automatic send_cmd(input ddet_pkg::t_cmd c);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            start <= 1'b0;
            i_cmd <= ddet_pkg::t_cmd'(16'($urandom));
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic load_entry(input logic [2:0] op, input logic [2:0] p,
                              input logic [1:0] r, input logic [7:0] v);
        send_cmd(make_cmd(op, p, r, v));
    endtask

    task automatic issue_run();
        send_cmd(make_cmd(ddet_pkg::OP_RUN, 3'($urandom), 2'($urandom), 8'($urandom)));
    endtask

    // hold start low until every run has reported
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (runs_outstanding != 0) @(posedge i_clk);
    endtask

    // random load item with any table opcode
    task automatic random_load();
        load_entry(3'($urandom_range(0, 3)), 3'($urandom), 2'($urandom), pick_count());
    endtask

    // timeout
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int kind;
        int n;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = '0;
        gaps_on    = 1'b1;
        items_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty tables, nothing held, nothing requested
        issue_run();
        // highest process asks for the most of the highest resource
        load_entry(ddet_pkg::OP_LOAD_REQ, 3'd7, 2'd3, 8'd255);
        issue_run();
        load_entry(ddet_pkg::OP_LOAD_EXIST, 3'd0, 2'd3, 8'd255);
        issue_run();
        // second vector above existing clamps work to zero
        load_entry(ddet_pkg::OP_LOAD_SECOND, 3'd7, 2'd0, 8'd1);
        load_entry(ddet_pkg::OP_LOAD_REQ, 3'd0, 2'd0, 8'd1);
        issue_run();
        // a release by process seven unblocks process zero
        load_entry(ddet_pkg::OP_LOAD_ALLOC, 3'd7, 2'd0, 8'd1);
        issue_run();
        // unknown codes leave the tables alone
        load_entry(3'd5, 3'd0, 2'd0, 8'd0);
        load_entry(3'd6, 3'd7, 2'd3, 8'd255);
        load_entry(3'd7, 3'd5, 2'd2, 8'd170);
        issue_run();
        // work saturation on resource one
        load_entry(ddet_pkg::OP_LOAD_EXIST, 3'd0, 2'd1, 8'd255);
        for (int p = 0; p < 8; p++) begin
            load_entry(ddet_pkg::OP_LOAD_ALLOC, 3'(p), 2'd1, 8'd255);
        end
        issue_run();
        wait_for_results();

        // random scenarios, gaps switched off near the end
        while (items_sent < NUM_ITEMS) begin
            gaps_on = (items_sent < NUM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 4) != 0);
            kind    = $urandom_range(0, 9);
            if (kind <= 5) begin
                // scattered loads then a run
                n = $urandom_range(1, 16);
                repeat (n) random_load();
                issue_run();
            end else if (kind == 6) begin
                // rebuild the request table with small demands
                for (int r = 0; r < 4; r++) begin
                    load_entry(ddet_pkg::OP_LOAD_EXIST, 3'($urandom), 2'(r),
                               8'($urandom_range(0, 6)));
                    for (int p = 0; p < 8; p++) begin
                        load_entry(ddet_pkg::OP_LOAD_REQ, 3'(p), 2'(r),
                                   8'($urandom_range(0, 2)));
                    end
                end
                issue_run();
            end else if (kind == 7) begin
                // unknown codes mixed with loads
                n = $urandom_range(1, 6);
                repeat (n) begin
                    load_entry(3'($urandom_range(5, 7)), 3'($urandom), 2'($urandom),
                               8'($urandom));
                    random_load();
                end
                issue_run();
            end else if (kind == 8) begin
                // runs back to back
                n = $urandom_range(1, 3);
                repeat (n) issue_run();
            end else begin
                // any opcode at all
                n = $urandom_range(1, 8);
                repeat (n) begin
                    send_cmd(make_cmd(3'($urandom), 3'($urandom), 2'($urandom),
                                      8'($urandom)));
                end
            end
            if ((items_sent < NUM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 39) == 0)) begin
                wait_for_results();
            end
        end

        // drain and give the block time to settle
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && runs_outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/ddet_pkg.sv
hdl/deadlock_detector.sv
hdl/ddet_chk.sv
verif/ddet_checker.sv
verif/deadlock_detector_tb.sv
